// File: src/msa_pkg.sv
package msa_pkg;

	// Width of the value fields on the ports.
	localparam int IO_WIDTH = 32;
	// Widest element the store can hold; values are sign-extended to this width.
	localparam int EXT_WIDTH = 64;

	// Default configuration.
	localparam int MAX_COUNT_DEF  = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_we;   // write the incoming element into the first buffer
		logic merge_we;  // write the merge winner into the destination buffer
		logic src_sel;   // buffer that holds the current runs (0 or 1)
		logic take_a;    // the left run supplies the next merged element
		logic out_load;  // load the output register with the source read
		logic out_last;  // the loaded beat is the final one of the set
		logic out_ovf;   // the set had elements dropped
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic a_le_b;    // left head is not greater than right head
		logic out_busy;  // output register holds a beat that is not taken
	} stat_t;

endpackage

// File: src/merge_sort_ascending.sv
// Loading takes input beats without stalling; the set closes on the beat with in_last.
// Sorting then runs ceil(log2 n) merge passes, each element read (ST_RD) and compared and
// written (ST_CMP) through the two-read-port buffer RAM, and the n results follow, each
// read (ST_EMIT_RD) and loaded into the output register (ST_EMIT_OUT). Input stalls
// from the last beat until the last result is loaded.
// Reset clears the controller and the output valid flag; buffer contents are not cleared.
module merge_sort_ascending #(
	parameter int MAX_COUNT = msa_pkg::MAX_COUNT_DEF,
	parameter int DATA_WIDTH = msa_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [msa_pkg::IO_WIDTH-1:0] in_value,
	input  logic                                in_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [msa_pkg::IO_WIDTH-1:0] out_value,
	output logic                                out_last,
	output logic                                overflow
);

	import msa_pkg::*;

	localparam int ADDR_W = $clog2(MAX_COUNT);

	cmd_t              cmd;
	stat_t             stat;
	logic [ADDR_W-1:0] rd_addr0;
	logic [ADDR_W-1:0] rd_addr1;
	logic [ADDR_W-1:0] wr_addr;

	// Sequencer for loading, merge passes and emission.
	msa_ctrl #(
		.MAX_COUNT (MAX_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.wr_addr  (wr_addr)
	);

	// Buffers, comparator and output register.
	msa_dp #(
		.MAX_COUNT  (MAX_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  (in_value),
		.cmd       (cmd),
		.stat      (stat),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.wr_addr   (wr_addr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.out_last  (out_last),
		.overflow  (overflow)
	);

endmodule

// File: src/msa_ram.sv
module msa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr0,
	input  logic [ADDR_W-1:0] raddr1,
	output logic [WIDTH-1:0]  rdata0,
	output logic [WIDTH-1:0]  rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

// File: src/msa_ctrl.sv
module msa_ctrl #(
	parameter int MAX_COUNT = 64,
	localparam int ADDR_W = $clog2(MAX_COUNT),
	localparam int CNT_W = $clog2(MAX_COUNT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_stall,
	input  msa_pkg::stat_t    stat,
	output msa_pkg::cmd_t     cmd,
	output logic [ADDR_W-1:0] rd_addr0,
	output logic [ADDR_W-1:0] rd_addr1,
	output logic [ADDR_W-1:0] wr_addr
);

	import msa_pkg::*;

	localparam int WID_W = CNT_W + 1;
	localparam int SUM_W = CNT_W + 2;

	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_WCHK     = 3'd1;
	localparam logic [2:0] ST_LCHK     = 3'd2;
	localparam logic [2:0] ST_RD       = 3'd3;
	localparam logic [2:0] ST_CMP      = 3'd4;
	localparam logic [2:0] ST_EMIT_RD  = 3'd5;
	localparam logic [2:0] ST_EMIT_OUT = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             dropped_q;
	logic [CNT_W-1:0] n_q;
	logic [WID_W-1:0] width_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] a_q;
	logic [CNT_W-1:0] b_q;
	logic [CNT_W-1:0] k_q;
	logic             src_q;

	logic             accept;
	logic             room;
	logic [SUM_W-1:0] lo_mid;
	logic [SUM_W-1:0] lo_hi;
	logic [CNT_W-1:0] mid_min;
	logic [CNT_W-1:0] hi_min;
	logic             a_left;
	logic             b_left;
	logic             take_a;
	logic [CNT_W-1:0] k_next;
	logic             emitting;

	assign accept = in_valid && (state_q == ST_LOAD);
	assign room   = cnt_q < CNT_W'(MAX_COUNT);
	assign in_stall = (state_q != ST_LOAD);

	// Bounds of the next pair of runs, clipped to the set size.
	assign lo_mid  = SUM_W'(lo_q) + SUM_W'(width_q);
	assign lo_hi   = SUM_W'(lo_q) + SUM_W'({width_q, 1'b0});
	assign mid_min = (lo_mid < SUM_W'(n_q)) ? CNT_W'(lo_mid) : n_q;
	assign hi_min  = (lo_hi < SUM_W'(n_q)) ? CNT_W'(lo_hi) : n_q;

	// Merge choice: the left run wins ties and takes over once the right is empty.
	assign a_left = a_q < mid_q;
	assign b_left = b_q < hi_q;
	assign take_a = a_left && (!b_left || stat.a_le_b);
	assign k_next = k_q + CNT_W'(1);

	assign emitting = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_OUT);

	// Command and address outputs to the datapath.
	always_comb begin
		cmd.load_we  = accept && room;
		cmd.merge_we = (state_q == ST_CMP);
		cmd.src_sel  = src_q;
		cmd.take_a   = take_a;
		cmd.out_load = (state_q == ST_EMIT_OUT) && !stat.out_busy;
		cmd.out_last = (k_next == n_q);
		cmd.out_ovf  = dropped_q;
		rd_addr0 = emitting ? k_q[ADDR_W-1:0] : a_q[ADDR_W-1:0];
		rd_addr1 = b_q[ADDR_W-1:0];
		wr_addr  = (state_q == ST_LOAD) ? cnt_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
	end

	// Sequencer: load, merge passes of doubling width, then emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			n_q       <= '0;
			width_q   <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			k_q       <= '0;
			src_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (in_last) begin
							n_q     <= room ? cnt_q + CNT_W'(1) : cnt_q;
							width_q <= WID_W'(1);
							src_q   <= 1'b0;
							state_q <= ST_WCHK;
						end
					end
				end
				ST_WCHK: begin
					if (width_q < WID_W'(n_q)) begin
						lo_q    <= '0;
						state_q <= ST_LCHK;
					end else begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_LCHK: begin
					if (lo_q < n_q) begin
						mid_q   <= mid_min;
						hi_q    <= hi_min;
						a_q     <= lo_q;
						b_q     <= mid_min;
						k_q     <= lo_q;
						state_q <= ST_RD;
					end else begin
						width_q <= {width_q[WID_W-2:0], 1'b0};
						src_q   <= ~src_q;
						state_q <= ST_WCHK;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					k_q <= k_next;
					if (take_a) begin
						a_q <= a_q + CNT_W'(1);
					end else begin
						b_q <= b_q + CNT_W'(1);
					end
					if (k_next == hi_q) begin
						lo_q    <= hi_q;
						state_q <= ST_LCHK;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (!stat.out_busy) begin
						if (k_next == n_q) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							k_q     <= k_next;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// File: src/msa_dp.sv
module msa_dp #(
	parameter int MAX_COUNT = 64,
	parameter int DATA_WIDTH = 32,
	localparam int ADDR_W = $clog2(MAX_COUNT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [msa_pkg::IO_WIDTH-1:0] in_value,
	input  msa_pkg::cmd_t                       cmd,
	output msa_pkg::stat_t                      stat,
	input  logic [ADDR_W-1:0]                   rd_addr0,
	input  logic [ADDR_W-1:0]                   rd_addr1,
	input  logic [ADDR_W-1:0]                   wr_addr,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [msa_pkg::IO_WIDTH-1:0] out_value,
	output logic                                out_last,
	output logic                                overflow
);

	import msa_pkg::*;

	logic signed [EXT_WIDTH-1:0]  in_ext;
	logic signed [DATA_WIDTH-1:0] in_elem;
	logic signed [DATA_WIDTH-1:0] m0_rd0;
	logic signed [DATA_WIDTH-1:0] m0_rd1;
	logic signed [DATA_WIDTH-1:0] m1_rd0;
	logic signed [DATA_WIDTH-1:0] m1_rd1;
	logic signed [DATA_WIDTH-1:0] src_rd0;
	logic signed [DATA_WIDTH-1:0] src_rd1;
	logic signed [DATA_WIDTH-1:0] wr_data;
	logic signed [EXT_WIDTH-1:0]  out_ext;
	logic                         we0;
	logic                         we1;
	logic                         out_valid_q;
	logic [IO_WIDTH-1:0]          out_value_q;
	logic                         out_last_q;
	logic                         overflow_q;

	// Reduce the incoming value to the element width.
	assign in_ext  = EXT_WIDTH'(in_value);
	assign in_elem = in_ext[DATA_WIDTH-1:0];

	// Ping-pong buffers: one holds the runs, the other receives the merge.
	assign we0 = cmd.load_we || (cmd.merge_we && cmd.src_sel);
	assign we1 = cmd.merge_we && !cmd.src_sel;
	assign src_rd0 = cmd.src_sel ? m1_rd0 : m0_rd0;
	assign src_rd1 = cmd.src_sel ? m1_rd1 : m0_rd1;
	assign wr_data = cmd.load_we ? in_elem : (cmd.take_a ? src_rd0 : src_rd1);

	msa_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_COUNT)
	) u_buf0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (wr_addr),
		.wdata  (wr_data),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (m0_rd0),
		.rdata1 (m0_rd1)
	);

	msa_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_COUNT)
	) u_buf1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (wr_addr),
		.wdata  (wr_data),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (m1_rd0),
		.rdata1 (m1_rd1)
	);

	// Signed comparison of the two run heads.
	assign stat.a_le_b   = (src_rd0 <= src_rd1);
	assign stat.out_busy = out_valid_q && out_stall;

	// Sign-extend the emitted element back to the port width.
	assign out_ext = EXT_WIDTH'(src_rd0);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= out_ext[IO_WIDTH-1:0];
			out_last_q  <= cmd.out_last;
			overflow_q  <= cmd.out_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign overflow  = overflow_q;

endmodule

// File: test/merge_sort_checker.sv
module merge_sort_checker #(
	parameter int MAX_COUNT = msa_pkg::MAX_COUNT_DEF,
	parameter int DATA_WIDTH = msa_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [msa_pkg::IO_WIDTH-1:0] in_value,
	input  logic                                in_last,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [msa_pkg::IO_WIDTH-1:0] out_value,
	input  logic                                out_last,
	input  logic                                overflow,
	output int                                  errors,
	output int                                  pending
);
	import msa_pkg::*;

	// One sorted output beat as it should appear on the result channel.
	typedef struct packed {
		logic [IO_WIDTH-1:0] value;
		logic                last;
		logic                ovf;
	} sorted_beat_t;

	// Elements of the set being collected, held sign-extended to the wide format.
	logic signed [EXT_WIDTH-1:0] held_vals [MAX_COUNT];
	logic signed [EXT_WIDTH-1:0] merge_buf [MAX_COUNT];
	int                          held_count;
	logic                        held_dropped;
	sorted_beat_t                sorted_expect [$];
	sorted_beat_t                beat;
	int                          idx;

	// Reduce an incoming value to the element width and sign-extend it again.
	function automatic logic signed [EXT_WIDTH-1:0] to_store_width(
		input logic signed [IO_WIDTH-1:0] v
	);
		logic signed [EXT_WIDTH-1:0] w;
		w = v;
		w = w <<< (EXT_WIDTH - DATA_WIDTH);
		return w >>> (EXT_WIDTH - DATA_WIDTH);
	endfunction

	// Bottom-up merge sort of the first n held elements, ascending.
	function automatic void sort_held_set(input int n);
		int run, lo, mid, hi, a, b, k;
		for (run = 1; run < n; run = run * 2) begin
			for (lo = 0; lo + run < n; lo = lo + 2 * run) begin
				mid = lo + run;
				hi = (mid + run < n) ? mid + run : n;
				a = lo;
				b = mid;
				for (k = lo; k < hi; k++) begin
					// Equal heads are taken from the left run, which keeps the merge stable.
					if (b >= hi || (a < mid && held_vals[a] <= held_vals[b])) begin
						merge_buf[k] = held_vals[a];
						a++;
					end else begin
						merge_buf[k] = held_vals[b];
						b++;
					end
				end
				for (k = lo; k < hi; k++)
					held_vals[k] = merge_buf[k];
			end
		end
	endfunction

	// Collect accepted elements, predict the sorted set on its closing beat,
	// and compare every accepted result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			held_dropped = 1'b0;
			sorted_expect.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (held_count < MAX_COUNT) begin
					held_vals[held_count] = to_store_width(in_value);
					held_count++;
				end else begin
					held_dropped = 1'b1;
				end
				if (in_last) begin
					sort_held_set(held_count);
					for (idx = 0; idx < held_count; idx++) begin
						beat.value = held_vals[idx][IO_WIDTH-1:0];
						beat.last = (idx == held_count - 1);
						beat.ovf = held_dropped;
						sorted_expect = {sorted_expect, beat};
					end
					held_count = 0;
					held_dropped = 1'b0;
				end
			end

			if (out_valid && !out_stall) begin
				if (sorted_expect.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat: out_value %0d out_last %0b overflow %0b",
						$time, out_value, out_last, overflow);
				end else begin
					beat = sorted_expect.pop_front();
					if (out_value !== $signed(beat.value)) begin
						errors++;
						$display("%0t: out_value expected %0d, actual %0d",
							$time, $signed(beat.value), out_value);
					end
					if (out_last !== beat.last) begin
						errors++;
						$display("%0t: out_last expected %0b, actual %0b", $time, beat.last, out_last);
					end
					if (overflow !== beat.ovf) begin
						errors++;
						$display("%0t: overflow expected %0b, actual %0b", $time, beat.ovf, overflow);
					end
				end
			end

			pending = sorted_expect.size();
		end
	end

endmodule

// File: test/tb.sv
module tb;
	import msa_pkg::*;

	localparam int MAX_COUNT = 64;
	localparam int DATA_WIDTH = 32;
	// Cycle limit for the whole run; the whole run stays far below this.
	localparam int CYCLE_LIMIT = 400000;
	// Quiet time after the last expected result to catch stray beats.
	localparam int DRAIN_CYCLES = 100;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [IO_WIDTH-1:0] in_value = '0;
	logic                       in_last = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [IO_WIDTH-1:0] out_value;
	logic                       out_last;
	logic                       overflow;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	int errors;
	int pending;

	merge_sort_ascending #(
		.MAX_COUNT(MAX_COUNT),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_value(in_value),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_value(out_value),
		.out_last(out_last),
		.overflow(overflow)
	);

	merge_sort_checker #(
		.MAX_COUNT(MAX_COUNT),
		.DATA_WIDTH(DATA_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_value(in_value),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_value(out_value),
		.out_last(out_last),
		.overflow(overflow),
		.errors(errors),
		.pending(pending)
	);

	// Clock with a period of 20.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The result side stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("merge_sort_ascending: mismatch");
			$finish;
		end
	end

	// Offer one element after a random idle gap and hold it until it is taken.
	task automatic send_beat(input logic signed [IO_WIDTH-1:0] v, input logic l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_value <= v;
		in_last <= l;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold the input idle until every predicted result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Random element: full range, a narrow band that produces ties, or an extreme.
	function automatic logic signed [IO_WIDTH-1:0] rand_value();
		logic signed [IO_WIDTH-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			1: v = v >>> (IO_WIDTH - 4);
			2: begin
				case ($urandom_range(0, 3))
					0: v = {1'b0, {(IO_WIDTH-1){1'b1}}};
					1: v = {1'b1, {(IO_WIDTH-1){1'b0}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// One set of n random elements, the last one closing the set.
	task automatic send_set(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_beat(rand_value(), i == n - 1);
	endtask

	// Stimulus: corner sets first, then random sets in three idling phases.
	initial begin
		logic signed [IO_WIDTH-1:0] corner_vals [10];
		int phase, sent, n, i;

		corner_vals = '{
			32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
			32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff, -32'sd1, 32'sh80000000
		};
		send_idle_pct = 30;
		recv_idle_pct = 46;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the value range with duplicates, in scrambled order.
		for (i = 0; i < 10; i++)
			send_beat(corner_vals[i], i == 9);
		// A set of one, an ordered pair, a reversed pair, and an all-equal set.
		send_beat(-32'sd5, 1'b1);
		send_beat(32'sd3, 1'b0);
		send_beat(32'sd4, 1'b1);
		send_beat(32'sd4, 1'b0);
		send_beat(32'sd3, 1'b1);
		send_beat(32'sd7, 1'b0);
		send_beat(32'sd7, 1'b0);
		send_beat(32'sd7, 1'b1);
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// A set that fills the store exactly and then drops its closing beat.
			if (phase == 0)
				send_set(MAX_COUNT + 1);
			sent = 0;
			while (sent < 6) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
				send_set(n);
				sent += n;
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("merge_sort_ascending: match");
		else
			$display("merge_sort_ascending: mismatch");
		$finish;
	end

endmodule

// File: files.f
src/msa_pkg.sv
src/msa_ram.sv
src/msa_ctrl.sv
src/msa_dp.sv
src/merge_sort_ascending.sv
test/merge_sort_checker.sv
test/tb.sv
